>>> rtl/core/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, codes and state types.
// Depends on nothing; used by the interface file and every module.
`default_nettype none
package ffha_pkg;
  localparam int unsigned HeapUnitsDefault = 4096;
  localparam int unsigned UnitShift        = 3;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusZero    = 2'd1;
  localparam logic [1:0] StatusNoFit   = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] request_bytes;
    logic [14:0] release_address;
  } ffha_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] payload_address;
    logic [15:0] free_bytes;
    logic [15:0] taken_bytes;
  } ffha_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StAllocRead,
    StAllocCheck,
    StAllocSplit,
    StFreeRead,
    StFreeCheck,
    StMergeRead,
    StMergeNext,
    StMergeCheck,
    StMergeFetch,
    StRespond
  } ffha_state_e;
endpackage
`default_nettype wire

>>> rtl/core/ffha_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on ffha_pkg for the payload types.
`default_nettype none
interface ffha_req_if;
  logic                valid;
  logic                ready;
  ffha_pkg::ffha_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffha_rsp_if;
  logic                valid;
  logic                ready;
  ffha_pkg::ffha_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ffha_heap_mem.sv
// Header store: block size and free mark per heap unit, one port.
// Depends on ffha_pkg.
`default_nettype none
module ffha_heap_mem #(
  parameter int unsigned HeapUnits = ffha_pkg::HeapUnitsDefault,
  localparam int unsigned AW = $clog2(HeapUnits),
  localparam int unsigned SW = AW + 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [SW-1:0] wsize_i,
  input  wire logic          wfree_i,
  output logic      [SW-1:0] rsize_o,
  output logic               rfree_o
);
  import ffha_pkg::*;
  logic [SW:0] mem_q [HeapUnits];

  // Single-port memory, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= {wfree_i, wsize_i};
    end
    {rfree_o, rsize_o} <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> rtl/core/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator.
// Depends on ffha_pkg, ffha_if and ffha_heap_mem.
//
// A request is taken one at a time; the block is busy until its response is
// taken. The heap of HeapUnits 8-byte units is described by headers in a
// single-port memory, walked one header at a time by a shared adder and
// compare. An allocate walks the headers from the start to the first free
// block that is large enough, and splits it when more than one unit would
// remain; an allocate of zero bytes or of more than the heap goes straight
// to the response. A free walks to its header and marks it free, then runs a
// merge pass over the whole list that absorbs free neighbors into free blocks.
// A null or misaligned free changes nothing. Entry 0 is written while init_q
// is still clear after reset release, when no request is taken. The response
// holds status, the payload offset and the free and taken byte totals.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int unsigned HeapUnits = ffha_pkg::HeapUnitsDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp
);
  import ffha_pkg::*;
  localparam int unsigned AW = $clog2(HeapUnits);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] HeapSize = SW'(HeapUnits);

  ffha_state_e state_q, state_d;
  logic          init_q;
  logic [SW-1:0] at_q, at_d;        // current header
  logic [SW-1:0] nx_q, nx_d;        // next header in merge
  logic [SW-1:0] asz_q, asz_d;      // size of header at at_q in merge
  logic [SW-1:0] need_q, need_d;    // units needed, or target header
  logic [SW-1:0] taken_q, taken_d;
  logic [1:0]    status_q, status_d;
  logic [SW-1:0] pay_q, pay_d;      // granted header unit + 1

  logic          we;
  logic [AW-1:0] maddr;
  logic [SW-1:0] wsize, rsize;
  logic          wfree, rfree;

  ffha_heap_mem #(.HeapUnits(HeapUnits)) u_mem (
    .clk_i, .we_i(we), .addr_i(maddr), .wsize_i(wsize), .wfree_i(wfree),
    .rsize_o(rsize), .rfree_o(rfree)
  );

  // Shared adder: next header position. After an absorb the merged size
  // held in asz_q steps the walk; otherwise the size just read does.
  logic [SW-1:0] step;
  logic [SW:0] sum;
  logic [SW-1:0] nxt;
  assign step = (state_q == StMergeFetch) ? asz_q : rsize;
  assign sum = {1'b0, at_q} + {1'b0, step};
  assign nxt = (step == '0 || sum >= (SW+1)'(HeapUnits)) ? HeapSize : sum[SW-1:0];

  logic [SW-1:0] rest;
  assign rest = rsize - need_q;

  // Units an allocate needs, header included, kept wide enough for any size.
  logic [16:0] need_full;
  assign need_full = ((17'(req.data.request_bytes) + 17'd7) >> UnitShift) + 17'd1;

  // Next state and datapath.
  always_comb begin
    state_d  = state_q;
    at_d     = at_q;
    nx_d     = nx_q;
    asz_d    = asz_q;
    need_d   = need_q;
    taken_d  = taken_q;
    status_d = status_q;
    pay_d    = pay_q;
    case (state_q)
      StIdle: begin
        if (req.valid && init_q) begin
          at_d = '0;
          pay_d = '0;
          status_d = StatusDone;
          if (req.data.cmd == CmdAlloc) begin
            if (req.data.request_bytes == '0) begin
              status_d = StatusZero;
              state_d = StRespond;
            end else if (32'(need_full) > HeapUnits) begin
              // Larger than the whole heap: no block can fit.
              status_d = StatusNoFit;
              state_d = StRespond;
            end else begin
              need_d = SW'(need_full);
              status_d = StatusNoFit;
              state_d = StAllocRead;
            end
          end else if (req.data.release_address != '0 &&
                       req.data.release_address[2:0] == 3'd0) begin
            need_d = SW'(req.data.release_address >> UnitShift) - 1'b1;
            state_d = StFreeRead;
          end else begin
            state_d = StRespond;
          end
        end
      end
      StAllocRead: state_d = StAllocCheck;
      StAllocCheck: begin
        if (rfree && rsize >= need_q) begin
          status_d = StatusDone;
          pay_d = at_q + 1'b1;
          if (rest > SW'(1) && ({1'b0, at_q} + {1'b0, need_q}) < (SW+1)'(HeapUnits)) begin
            taken_d = taken_q + need_q;
            state_d = StAllocSplit;
          end else begin
            taken_d = taken_q + rsize;
            state_d = StRespond;
          end
        end else if (nxt >= HeapSize) begin
          state_d = StRespond;
        end else begin
          at_d = nxt;
          state_d = StAllocRead;
        end
      end
      StAllocSplit: state_d = StRespond;
      StFreeRead: state_d = StFreeCheck;
      StFreeCheck: begin
        if (at_q == need_q) begin
          if (!rfree) taken_d = taken_q - rsize;
          at_d = '0;
          state_d = StMergeRead;
        end else if (nxt >= HeapSize || nxt > need_q) begin
          state_d = StRespond;
        end else begin
          at_d = nxt;
          state_d = StFreeRead;
        end
      end
      StMergeRead: state_d = StMergeNext;
      StMergeNext: begin
        // Header at at_q is in rsize/rfree now.
        asz_d = rsize;
        nx_d = nxt;
        if (nxt >= HeapSize) state_d = StRespond;
        else if (!rfree) begin
          at_d = nxt;
          state_d = StMergeRead;
        end else state_d = StMergeCheck;
      end
      StMergeCheck: begin
        // Next header data in rsize/rfree; current free.
        if (rfree) begin
          asz_d = asz_q + rsize;
          state_d = StMergeFetch;
        end else begin
          at_d = nx_q;
          state_d = StMergeRead;
        end
      end
      StMergeFetch: begin
        // Read the header that follows the grown block, if there is one.
        if (nxt >= HeapSize) state_d = StRespond;
        else begin
          nx_d = nxt;
          state_d = StMergeCheck;
        end
      end
      StRespond: if (rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Memory port control.
  always_comb begin
    we = 1'b0;
    maddr = at_q[AW-1:0];
    wsize = rsize;
    wfree = 1'b0;
    case (state_q)
      StIdle: begin
        if (!init_q) begin
          we = 1'b1;
          maddr = '0;
          wsize = HeapSize;
          wfree = 1'b1;
        end
      end
      StAllocCheck: begin
        if (rfree && rsize >= need_q) begin
          we = 1'b1;
          wfree = 1'b0;
          wsize = (rest > SW'(1) && ({1'b0, at_q} + {1'b0, need_q}) <
                   (SW+1)'(HeapUnits)) ? need_q : rsize;
        end
      end
      StAllocSplit: begin
        we = 1'b1;
        maddr = AW'(at_q + need_q);
        wsize = asz_q;
        wfree = 1'b1;
      end
      StFreeCheck: begin
        if (at_q == need_q) begin
          we = 1'b1;
          wfree = 1'b1;
        end
      end
      StMergeNext: maddr = nxt[AW-1:0];
      StMergeCheck: begin
        if (rfree) begin
          we = 1'b1;
          wsize = asz_q + rsize;
          wfree = 1'b1;
          maddr = at_q[AW-1:0];
        end
      end
      StMergeFetch: maddr = nxt[AW-1:0];
      default: ;
    endcase
  end

  // Remainder size for the split header is held in asz_q.
  logic [SW-1:0] asz_n;
  assign asz_n = (state_q == StAllocCheck) ? rest : asz_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      init_q   <= 1'b0;
      taken_q  <= '0;
      at_q     <= '0;
      nx_q     <= '0;
      asz_q    <= '0;
      need_q   <= '0;
      status_q <= StatusDone;
      pay_q    <= '0;
    end else begin
      init_q   <= 1'b1;
      state_q  <= state_d;
      taken_q  <= taken_d;
      at_q     <= at_d;
      nx_q     <= nx_d;
      asz_q    <= asz_n;
      need_q   <= need_d;
      status_q <= status_d;
      pay_q    <= pay_d;
    end
  end

  assign req.ready = (state_q == StIdle) && init_q;
  assign rsp.valid = (state_q == StRespond);
  assign rsp.data.status = status_q;
  assign rsp.data.payload_address = 15'({pay_q, 3'b000});
  assign rsp.data.free_bytes  = 16'({HeapSize - taken_q, 3'b000});
  assign rsp.data.taken_bytes = 16'({taken_q, 3'b000});
endmodule
`default_nettype wire
